// File: design/gcne_pkg.sv
// ----------------------------------------------------------------------------
// gcne_pkg
// Shared types and constants for the grid cell neighbour enumerator.
// ----------------------------------------------------------------------------
package gcne_pkg;

    localparam int GRID_COLS_DEF = 16;
    localparam int GRID_ROWS_DEF = 16;

    localparam int COORD_W = 24;   // signed Q15.8 position
    localparam int EXT_W   = 23;   // unsigned Q15.8 extent / radius
    localparam int CELL_W  = 9;    // signed cell index
    localparam int QUO_W   = 8;    // raw quotient bits
    localparam int NPTS    = 5;    // centre, east, north, west, south
    localparam int NSLOTS  = 9;    // result slots per item

    localparam logic [1:0] REG_WORLD_WIDTH  = 2'd0;
    localparam logic [1:0] REG_WORLD_LENGTH = 2'd1;
    localparam logic [1:0] REG_CELL_WIDTH   = 2'd2;
    localparam logic [1:0] REG_CELL_LENGTH  = 2'd3;

    localparam logic [EXT_W-1:0] WORLD_WIDTH_RST  = 23'd262144;
    localparam logic [EXT_W-1:0] WORLD_LENGTH_RST = 23'd262144;
    localparam logic [EXT_W-1:0] CELL_WIDTH_RST   = 23'd16384;
    localparam logic [EXT_W-1:0] CELL_LENGTH_RST  = 23'd16384;

    localparam logic [CELL_W-1:0] CELL_NONE = 9'h1FF;

    // point order inside a record
    localparam int PT_C = 0;
    localparam int PT_E = 1;
    localparam int PT_N = 2;
    localparam int PT_W = 3;
    localparam int PT_S = 4;

    typedef struct packed {
        logic load;
        logic step;
        logic first;
    } div_ctrl_t;

    typedef struct packed {
        logic [NPTS-1:0][CELL_W-1:0] cx;
        logic [NPTS-1:0][CELL_W-1:0] cz;
        logic [3:0]                  diff;  // {S, W, N, E} differ from centre
    } gcne_rec_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_RUN,
        F_DONE
    } front_state_t;

endpackage

// File: design/gcne_div.sv
// ----------------------------------------------------------------------------
// gcne_div
// Restoring divider for one axis: a first step checks for overflow, then one quotient bit per step, saturated index.
// ----------------------------------------------------------------------------
module gcne_div #(
    parameter int LIMIT = gcne_pkg::GRID_COLS_DEF
) (
    input  logic                      clk,
    input  gcne_pkg::div_ctrl_t       ctrl,
    input  logic [gcne_pkg::EXT_W-1:0] dividend,
    input  logic [gcne_pkg::EXT_W-1:0] divisor,
    output logic [gcne_pkg::QUO_W-1:0] quot
);
    import gcne_pkg::*;

    localparam logic [QUO_W-1:0] MAX_IDX = QUO_W'(LIMIT - 1);

    logic [EXT_W-1:0]       rem_reg;
    logic [EXT_W+QUO_W-1:0] dsh_reg;
    logic [QUO_W-1:0]       q_reg;
    logic                   sat_reg;
    logic                   ge;
    logic [QUO_W-1:0]       q_full;

    assign ge = {{QUO_W{1'b0}}, rem_reg} >= dsh_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            rem_reg <= dividend;
            dsh_reg <= {divisor, {QUO_W{1'b0}}};
            q_reg   <= '0;
            sat_reg <= (divisor == '0);
        end
        else if (ctrl.step)
        begin
            dsh_reg <= dsh_reg >> 1;
            if (ctrl.first)
            begin
                // quotient of 256 or more saturates
                sat_reg <= sat_reg | ge;
            end
            else if (ge)
            begin
                rem_reg <= rem_reg - dsh_reg[EXT_W-1:0];
                q_reg   <= {q_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                q_reg   <= {q_reg[QUO_W-2:0], 1'b0};
            end
        end
    end

    assign q_full = sat_reg ? {QUO_W{1'b1}} : q_reg;
    assign quot   = (q_full > MAX_IDX) ? MAX_IDX : q_full;

endmodule

// File: design/gcne_front.sv
// ----------------------------------------------------------------------------
// gcne_front
// Accept a query, map its five points to cells and classify the neighbours.
// ----------------------------------------------------------------------------
module gcne_front #(
    parameter int GRID_COLS = gcne_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS = gcne_pkg::GRID_ROWS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [gcne_pkg::COORD_W-1:0] pos_x,
    input  logic signed [gcne_pkg::COORD_W-1:0] pos_z,
    input  logic [gcne_pkg::EXT_W-1:0]    radius,
    input  logic [gcne_pkg::EXT_W-1:0]    world_width,
    input  logic [gcne_pkg::EXT_W-1:0]    world_length,
    input  logic [gcne_pkg::EXT_W-1:0]    cell_width,
    input  logic [gcne_pkg::EXT_W-1:0]    cell_length,
    output logic                          push_valid,
    input  logic                          push_ready,
    output gcne_pkg::gcne_rec_t           push_rec
);
    import gcne_pkg::*;

    localparam int DIV_STEPS = QUO_W + 1;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    front_state_t     state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NPTS-1:0]  pv_reg;
    logic             accept;
    div_ctrl_t        dctl;

    logic signed [COORD_W:0] px_pt [NPTS];
    logic signed [COORD_W:0] pz_pt [NPTS];
    logic [NPTS-1:0]         pv_in;
    logic [QUO_W-1:0]        qx [NPTS];
    logic [QUO_W-1:0]        qz [NPTS];
    logic [NPTS-1:0][CELL_W-1:0] ox, oz;

    function automatic logic in_world(input logic signed [COORD_W:0] p,
                                      input logic [EXT_W-1:0] w);
        return !p[COORD_W] && (p[COORD_W-1:0] < {1'b0, w});
    endfunction

    // offset points, one bit wider so nothing overflows
    always_comb
    begin
        logic signed [COORD_W:0] x0, z0, r0;
        x0 = {pos_x[COORD_W-1], pos_x};
        z0 = {pos_z[COORD_W-1], pos_z};
        r0 = {2'b00, radius};
        px_pt[PT_C] = x0;      pz_pt[PT_C] = z0;
        px_pt[PT_E] = x0 + r0; pz_pt[PT_E] = z0;
        px_pt[PT_N] = x0;      pz_pt[PT_N] = z0 + r0;
        px_pt[PT_W] = x0 - r0; pz_pt[PT_W] = z0;
        px_pt[PT_S] = x0;      pz_pt[PT_S] = z0 - r0;
        for (int k = 0; k < NPTS; k++)
        begin
            pv_in[k] = in_world(px_pt[k], world_width) && in_world(pz_pt[k], world_length);
        end
    end

    assign accept = in_valid && in_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_RUN;
                    cnt_next   = '0;
                end
            end
            F_RUN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = F_DONE;
                end
            end
            F_DONE:
            begin
                if (accept)
                begin
                    state_next = F_RUN;
                    cnt_next   = '0;
                end
                else if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready   = 1'b0;
        push_valid = 1'b0;
        dctl.step  = 1'b0;
        dctl.first = (cnt_reg == '0);
        unique case (state_reg)
            F_IDLE: in_ready = 1'b1;
            F_RUN:  dctl.step = 1'b1;
            F_DONE:
            begin
                push_valid = 1'b1;
                in_ready   = push_ready;
            end
            default: in_ready = 1'b0;
        endcase
        dctl.load = accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pv_reg <= pv_in;
        end
    end

    for (genvar k = 0; k < NPTS; k++)
    begin : g_pt
        gcne_div #(.LIMIT(GRID_COLS)) u_div_x (
            .clk      (clk),
            .ctrl     (dctl),
            .dividend (px_pt[k][EXT_W-1:0]),
            .divisor  (cell_width),
            .quot     (qx[k])
        );
        gcne_div #(.LIMIT(GRID_ROWS)) u_div_z (
            .clk      (clk),
            .ctrl     (dctl),
            .dividend (pz_pt[k][EXT_W-1:0]),
            .divisor  (cell_length),
            .quot     (qz[k])
        );
    end

    // fall back to the centre cell for any invalid offset point
    always_comb
    begin
        for (int k = 0; k < NPTS; k++)
        begin
            ox[k] = pv_reg[k] ? {1'b0, qx[k]} : CELL_NONE;
            oz[k] = pv_reg[k] ? {1'b0, qz[k]} : CELL_NONE;
        end
        push_rec.cx[PT_C] = ox[PT_C];
        push_rec.cz[PT_C] = oz[PT_C];
        for (int k = 1; k < NPTS; k++)
        begin
            push_rec.cx[k]     = pv_reg[k] ? ox[k] : ox[PT_C];
            push_rec.cz[k]     = pv_reg[k] ? oz[k] : oz[PT_C];
            push_rec.diff[k-1] = (push_rec.cx[k] != ox[PT_C]) ||
                                 (push_rec.cz[k] != oz[PT_C]);
        end
    end

endmodule

// File: design/gcne_fifo.sv
// ----------------------------------------------------------------------------
// gcne_fifo
// Two-entry queue of classified records between front and back.
// ----------------------------------------------------------------------------
module gcne_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  gcne_pkg::gcne_rec_t push_rec,
    output logic                pop_valid,
    input  logic                pop_ready,
    output gcne_pkg::gcne_rec_t pop_rec
);
    import gcne_pkg::*;

    gcne_rec_t  mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_push, do_pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_rec    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

// File: design/gcne_back.sv
// ----------------------------------------------------------------------------
// gcne_back
// Walk a record's emit mask and hand out one cell per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module gcne_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  gcne_pkg::gcne_rec_t pop_rec,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [gcne_pkg::CELL_W-1:0] cell_x,
    output logic [gcne_pkg::CELL_W-1:0] cell_z,
    output logic                last
);
    import gcne_pkg::*;

    gcne_rec_t         rec_reg;
    logic [NSLOTS-1:0] mask_reg, mask_after, low_bit, new_mask;
    logic              ov_reg, adv;
    logic [CELL_W-1:0] ox_reg, oz_reg, sx, sz;
    logic              olast_reg;
    logic              e, n, w, s;

    assign adv = (mask_reg != '0) && (!ov_reg || out_ready);

    // lowest pending slot
    assign low_bit    = mask_reg & (~mask_reg + 1'b1);
    assign mask_after = adv ? (mask_reg & ~low_bit) : mask_reg;
    assign pop_ready  = (mask_after == '0);

    assign e = pop_rec.diff[0];
    assign n = pop_rec.diff[1];
    assign w = pop_rec.diff[2];
    assign s = pop_rec.diff[3];
    // slot order: C, E, N, W, S, EN, WN, WS, ES
    assign new_mask = {e & s, w & s, w & n, e & n, s, w, n, e, 1'b1};

    always_comb
    begin
        priority if (low_bit[0]) begin sx = rec_reg.cx[PT_C]; sz = rec_reg.cz[PT_C]; end
        else if (low_bit[1])     begin sx = rec_reg.cx[PT_E]; sz = rec_reg.cz[PT_E]; end
        else if (low_bit[2])     begin sx = rec_reg.cx[PT_N]; sz = rec_reg.cz[PT_N]; end
        else if (low_bit[3])     begin sx = rec_reg.cx[PT_W]; sz = rec_reg.cz[PT_W]; end
        else if (low_bit[4])     begin sx = rec_reg.cx[PT_S]; sz = rec_reg.cz[PT_S]; end
        else if (low_bit[5])     begin sx = rec_reg.cx[PT_E]; sz = rec_reg.cz[PT_N]; end
        else if (low_bit[6])     begin sx = rec_reg.cx[PT_W]; sz = rec_reg.cz[PT_N]; end
        else if (low_bit[7])     begin sx = rec_reg.cx[PT_W]; sz = rec_reg.cz[PT_S]; end
        else                     begin sx = rec_reg.cx[PT_E]; sz = rec_reg.cz[PT_S]; end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            mask_reg <= (pop_valid && pop_ready) ? new_mask : mask_after;
            if (adv)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_valid && pop_ready)
        begin
            rec_reg <= pop_rec;
        end
        if (adv)
        begin
            ox_reg    <= sx;
            oz_reg    <= sz;
            olast_reg <= (mask_after == '0);
        end
    end

    assign out_valid = ov_reg;
    assign cell_x    = ox_reg;
    assign cell_z    = oz_reg;
    assign last      = olast_reg;

endmodule

// File: design/grid_cell_neighbour_enumerator.sv
// ----------------------------------------------------------------------------
// grid_cell_neighbour_enumerator
// Map a query point and radius to the grid cells the circle may touch.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | role
//  ---------+-------------------------------------------+---------------------
//  query    | in_valid/in_ready, pos_x, pos_z, radius   | one item per query
//  cells    | out_valid/out_ready, cell_x, cell_z, last | 1..9 items per query
//  config   | cfg_we, cfg_addr, cfg_wdata               | register writes
//
//  A query enters the front with a load and nine steps of the ten radix-2
//  dividers (one per axis per point); the next query enters in the cycle
//  its predecessor's record is queued. The back emits one cell a cycle
//  unless stalled. Reset clears control state and loads the default world
//  and cell extents. A two-entry record queue lets front and back stall
//  independently; the output register holds a cell until it is taken.
// ----------------------------------------------------------------------------
module grid_cell_neighbour_enumerator #(
    parameter int GRID_COLS = gcne_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS = gcne_pkg::GRID_ROWS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_addr,
    input  logic [gcne_pkg::EXT_W-1:0]        cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [gcne_pkg::COORD_W-1:0] pos_x,
    input  logic signed [gcne_pkg::COORD_W-1:0] pos_z,
    input  logic [gcne_pkg::EXT_W-1:0]        radius,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [gcne_pkg::CELL_W-1:0] cell_x,
    output logic signed [gcne_pkg::CELL_W-1:0] cell_z,
    output logic                              last
);
    import gcne_pkg::*;

    logic [EXT_W-1:0] world_width_reg, world_length_reg;
    logic [EXT_W-1:0] cell_width_reg, cell_length_reg;

    logic      push_valid, push_ready, pop_valid, pop_ready;
    gcne_rec_t push_rec, pop_rec;
    logic [CELL_W-1:0] cx, cz;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            world_width_reg  <= WORLD_WIDTH_RST;
            world_length_reg <= WORLD_LENGTH_RST;
            cell_width_reg   <= CELL_WIDTH_RST;
            cell_length_reg  <= CELL_LENGTH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_WORLD_WIDTH:  world_width_reg  <= cfg_wdata;
                REG_WORLD_LENGTH: world_length_reg <= cfg_wdata;
                REG_CELL_WIDTH:   cell_width_reg   <= cfg_wdata;
                REG_CELL_LENGTH:  cell_length_reg  <= cfg_wdata;
                default:          cell_length_reg  <= cell_length_reg;
            endcase
        end
    end

    // front: accept the query, divide, classify sides
    gcne_front #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pos_x        (pos_x),
        .pos_z        (pos_z),
        .radius       (radius),
        .world_width  (world_width_reg),
        .world_length (world_length_reg),
        .cell_width   (cell_width_reg),
        .cell_length  (cell_length_reg),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_rec     (push_rec)
    );

    // hold up to two classified queries
    gcne_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_rec   (push_rec),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_rec    (pop_rec)
    );

    // back: emit centre, sides, then diagonals
    gcne_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_rec   (pop_rec),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cell_x    (cx),
        .cell_z    (cz),
        .last      (last)
    );

    assign cell_x = signed'(cx);
    assign cell_z = signed'(cz);

endmodule

// File: tb/gcne_cell_checker.sv
// ----------------------------------------------------------------------------
// gcne_cell_checker
// Watches the query and cell channels, predicts the cells each accepted query
// touches and compares every accepted cell against the oldest prediction.
// ----------------------------------------------------------------------------
module gcne_cell_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [1:0]                           cfg_addr,
    input  logic [gcne_pkg::EXT_W-1:0]           cfg_wdata,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic signed [gcne_pkg::COORD_W-1:0]  pos_x,
    input  logic signed [gcne_pkg::COORD_W-1:0]  pos_z,
    input  logic [gcne_pkg::EXT_W-1:0]           radius,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic signed [gcne_pkg::CELL_W-1:0]   cell_x,
    input  logic signed [gcne_pkg::CELL_W-1:0]   cell_z,
    input  logic                                 last,
    output int                                   fail_count,
    output int                                   pending
);
    import gcne_pkg::*;

    localparam int COLS = GRID_COLS_DEF;
    localparam int ROWS = GRID_ROWS_DEF;

    typedef struct packed {
        logic signed [CELL_W-1:0] x;
        logic signed [CELL_W-1:0] z;
        logic                     fin;
    } cell_rec_t;

    typedef struct {
        longint x;
        longint z;
    } grid_pos_t;

    logic [EXT_W-1:0] world_w, world_l, cell_w, cell_l;
    cell_rec_t        cells_due[$];

    assign pending = cells_due.size();

    function automatic longint axis_cell(longint p, longint ext, int lim);
        longint q;
        if (ext == 0)
            return lim - 1;
        q = p / ext;
        return (q > lim - 1) ? lim - 1 : q;
    endfunction

    function automatic grid_pos_t cell_of(longint px, longint pz);
        grid_pos_t g;
        if (px < 0 || px >= world_w || pz < 0 || pz >= world_l)
        begin
            g.x = -1;
            g.z = -1;
        end
        else
        begin
            g.x = axis_cell(px, cell_w, COLS);
            g.z = axis_cell(pz, cell_l, ROWS);
        end
        return g;
    endfunction

    function automatic grid_pos_t side_cell(grid_pos_t c, longint px, longint pz);
        grid_pos_t g;
        g = cell_of(px, pz);
        return (g.x == -1 && g.z == -1) ? c : g;
    endfunction

    task automatic push_cell(longint x, longint z);
        cell_rec_t r;
        r.x   = x[CELL_W-1:0];
        r.z   = z[CELL_W-1:0];
        r.fin = 1'b0;
        cells_due.insert(cells_due.size(), r);
    endtask

    task automatic predict_cells(longint px, longint pz, longint r);
        grid_pos_t c, e, n, w, s;
        bit de, dn, dw, ds;
        c = cell_of(px, pz);
        e = side_cell(c, px + r, pz);
        n = side_cell(c, px, pz + r);
        w = side_cell(c, px - r, pz);
        s = side_cell(c, px, pz - r);
        de = (e.x != c.x) || (e.z != c.z);
        dn = (n.x != c.x) || (n.z != c.z);
        dw = (w.x != c.x) || (w.z != c.z);
        ds = (s.x != c.x) || (s.z != c.z);
        push_cell(c.x, c.z);
        if (de) push_cell(e.x, e.z);
        if (dn) push_cell(n.x, n.z);
        if (dw) push_cell(w.x, w.z);
        if (ds) push_cell(s.x, s.z);
        if (de && dn) push_cell(e.x, n.z);
        if (dw && dn) push_cell(w.x, n.z);
        if (dw && ds) push_cell(w.x, s.z);
        if (de && ds) push_cell(e.x, s.z);
        cells_due[cells_due.size() - 1].fin = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cell_rec_t exp_c;
        if (!rst_n)
        begin
            world_w    <= WORLD_WIDTH_RST;
            world_l    <= WORLD_LENGTH_RST;
            cell_w     <= CELL_WIDTH_RST;
            cell_l     <= CELL_LENGTH_RST;
            fail_count <= 0;
            cells_due.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_WORLD_WIDTH:  world_w <= cfg_wdata;
                    REG_WORLD_LENGTH: world_l <= cfg_wdata;
                    REG_CELL_WIDTH:   cell_w  <= cfg_wdata;
                    REG_CELL_LENGTH:  cell_l  <= cfg_wdata;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (cells_due.size() == 0)
                begin
                    $error("cell (%0d,%0d) with no query pending", cell_x, cell_z);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_c = cells_due.pop_front();
                    if (cell_x !== exp_c.x || cell_z !== exp_c.z || last !== exp_c.fin)
                    begin
                        if (cell_x !== exp_c.x)
                            $error("cell_x expected %0d got %0d", exp_c.x, cell_x);
                        if (cell_z !== exp_c.z)
                            $error("cell_z expected %0d got %0d", exp_c.z, cell_z);
                        if (last !== exp_c.fin)
                            $error("last expected %0b got %0b", exp_c.fin, last);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            // predict after the pop so the queue order holds
            if (in_valid && in_ready)
                predict_cells(longint'(pos_x), longint'(pos_z), longint'(radius));
        end
    end
endmodule

// File: tb/tb_grid_cell_neighbour_enumerator.sv
// ----------------------------------------------------------------------------
// tb_grid_cell_neighbour_enumerator
// Drives queries and register settings into the enumerator under random
// idling on both channels; the checker predicts and compares every cell.
// ----------------------------------------------------------------------------
module tb_grid_cell_neighbour_enumerator;
    import gcne_pkg::*;

    localparam longint CYCLE_LIMIT = 400000;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [1:0]                cfg_addr = REG_WORLD_WIDTH;
    logic [EXT_W-1:0]          cfg_wdata = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic signed [COORD_W-1:0] pos_x = '0;
    logic signed [COORD_W-1:0] pos_z = '0;
    logic [EXT_W-1:0]          radius = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [CELL_W-1:0]  cell_x;
    logic signed [CELL_W-1:0]  cell_z;
    logic                      last;
    int                        fail_count;
    int                        pending;

    // idle rates in percent; hold_off forces a long receiver stall
    int     send_idle = 17;
    int     recv_idle = 62;
    bit     hold_off = 1'b0;
    longint cycle_count = 0;

    always #5 clk = ~clk;

    grid_cell_neighbour_enumerator dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready),
        .pos_x(pos_x), .pos_z(pos_z), .radius(radius),
        .out_valid(out_valid), .out_ready(out_ready),
        .cell_x(cell_x), .cell_z(cell_z), .last(last)
    );

    gcne_cell_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready),
        .pos_x(pos_x), .pos_z(pos_z), .radius(radius),
        .out_valid(out_valid), .out_ready(out_ready),
        .cell_x(cell_x), .cell_z(cell_z), .last(last),
        .fail_count(fail_count), .pending(pending)
    );

    // Receiver: random stall at every falling edge, or hold fully low.
    always @(negedge clk)
    begin
        if (hold_off)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle);
    end

    // Watchdog: end the run with an error report once the cycle limit is passed.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_grid_cell_neighbour_enumerator: done, errors");
            $finish;
        end
    end

    // Offer one query, holding it until accepted; idle gaps come before it.
    // Valid stays high past the accepting edge only until the next falling
    // edge, where the next call replaces or drops it.
    task automatic send_query(logic signed [COORD_W-1:0] x,
                              logic signed [COORD_W-1:0] z,
                              logic [EXT_W-1:0] r);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        pos_x    <= x;
        pos_z    <= z;
        radius   <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drop valid, drain all cells, then let the front settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [EXT_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
    endtask

    task automatic set_grid(logic [EXT_W-1:0] ww, logic [EXT_W-1:0] wl,
                            logic [EXT_W-1:0] cw, logic [EXT_W-1:0] cl);
        wait_idle();
        write_reg(REG_WORLD_WIDTH, ww);
        write_reg(REG_WORLD_LENGTH, wl);
        write_reg(REG_CELL_WIDTH, cw);
        write_reg(REG_CELL_LENGTH, cl);
        cfg_we <= 1'b0;
    endtask

    // Mostly points in 0..world width on both axes with radii up to two cells,
    // the rest fully random to hit every bit and the outside region.
    task automatic random_query(logic [EXT_W-1:0] ww, logic [EXT_W-1:0] cw);
        logic signed [COORD_W-1:0] x, z;
        logic [EXT_W-1:0]          r;
        if ($urandom_range(3) != 0)
        begin
            x = COORD_W'($urandom_range(ww));
            z = COORD_W'($urandom_range(ww));
            r = EXT_W'($urandom_range(2 * cw));
        end
        else
        begin
            x = COORD_W'($urandom);
            z = COORD_W'($urandom);
            r = EXT_W'($urandom);
        end
        send_query(x, z, r);
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset grid, centre, edges, corners, extremes.
        send_query(24'sd100000, 24'sd100000, 23'd0);
        send_query(24'sd100000, 24'sd100000, 23'd20000);
        send_query(24'sd0, 24'sd0, 23'd16384);
        send_query(24'sd262143, 24'sd262143, 23'd1);
        send_query(24'sd262144, 24'sd5, 23'd4);
        send_query(-24'sd1, 24'sd100, 23'd300);
        send_query(-24'sd8388608, -24'sd8388608, 23'd8388607);
        send_query(24'sd8388607, 24'sd8388607, 23'd8388607);
        send_query(24'sd16383, 24'sd16384, 23'd1);
        send_query(24'sd200000, 24'sd30000, 23'd8388607);

        // Small cells: quotient saturates at the top column/row.
        set_grid(23'd8388607, 23'd8388607, 23'd1, 23'd1);
        send_query(24'sd1000, 24'sd3, 23'd2);
        send_query(24'sd8388606, 24'sd0, 23'd8388607);
        send_query(24'sd5, 24'sd10, 23'd3);

        // Zero cell extent: divider saturates.
        set_grid(23'd8388607, 23'd8388607, 23'd0, 23'd0);
        send_query(24'sd40, 24'sd40, 23'd50);

        // Zero world extent: every point invalid, one cell.
        set_grid(23'd0, 23'd0, 23'd16, 23'd16);
        send_query(24'sd0, 24'sd0, 23'd10);
        send_query(24'sd7, -24'sd7, 23'd8388607);

        // Tiny world and huge cells.
        set_grid(23'd1, 23'd1, 23'd8388607, 23'd8388607);
        send_query(24'sd0, 24'sd0, 23'd1);
        send_query(24'sd0, 24'sd0, 23'd0);

        // Random phase 1: small world, sender idle 17 %, receiver 62 %.
        set_grid(23'd4096, 23'd3000, 23'd256, 23'd200);
        repeat (40) random_query(23'd4096, 23'd256);

        // Random phase 2: swapped idling, with a long receiver hold-off.
        set_grid(23'd262144, 23'd200000, 23'd16384, 23'd9000);
        send_idle = 62;
        recv_idle = 17;
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(negedge clk);
                hold_off = 1'b0;
            end
            repeat (20) random_query(23'd262144, 23'd16384);
        join
        repeat (25) random_query(23'd262144, 23'd16384);

        // Random phase 3: no idling, default-like grid.
        set_grid(WORLD_WIDTH_RST, WORLD_LENGTH_RST, CELL_WIDTH_RST, CELL_LENGTH_RST);
        send_idle = 0;
        recv_idle = 0;
        repeat (30) random_query(WORLD_WIDTH_RST, CELL_WIDTH_RST);

        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        if (fail_count == 0)
            $display("tb_grid_cell_neighbour_enumerator: done, clean");
        else
            $display("tb_grid_cell_neighbour_enumerator: done, errors");
        $finish;
    end
endmodule
